>>> hw/rtl/olle_pkg.sv
// ----------------------------------------------------------------------------
// olle_pkg: shared types and constants of the ordered list engine
// Sizes, action and status codes, and the control word broadcast to the cells.
// ----------------------------------------------------------------------------
package olle_pkg;

  localparam int CAPACITY  = 16;
  localparam int CNT_W     = $clog2(CAPACITY + 1);
  localparam int DATA_W    = 32;
  localparam int ACT_W     = 3;
  localparam int STAT_W    = 2;
  localparam int OCNT_W    = 5;
  localparam int IN_TDATA_W  = ((ACT_W + DATA_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((STAT_W + OCNT_W + 7) / 8) * 8;

  localparam logic [ACT_W-1:0] ACT_INS_FRONT = 3'd0;
  localparam logic [ACT_W-1:0] ACT_INS_BACK  = 3'd1;
  localparam logic [ACT_W-1:0] ACT_REM_BACK  = 3'd2;
  localparam logic [ACT_W-1:0] ACT_REM_FRONT = 3'd3;
  localparam logic [ACT_W-1:0] ACT_REM_VALUE = 3'd4;

  localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
  localparam logic [STAT_W-1:0] ST_FULL      = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY     = 2'd2;
  localparam logic [STAT_W-1:0] ST_NOT_FOUND = 2'd3;

  // Control word seen by every cell in the same cycle.
  typedef struct packed {
    logic              shift_dn;   // insert at front: every cell takes its left neighbor
    logic              load_tail;  // insert at back: the cell at the tail takes the value
    logic              shift_up;   // remove front: every cell takes its right neighbor
    logic              rem_val;    // remove value: cells from the first match take right
    logic [DATA_W-1:0] value;
  } cell_ctrl_t;

endpackage

>>> hw/rtl/olle_cell.sv
// ----------------------------------------------------------------------------
// olle_cell: one slot of the ordered list
// Holds one entry, compares it against the search value and moves data
// to or from its neighbors.
// ----------------------------------------------------------------------------
module olle_cell (
  input  logic                               clk,
  input  olle_pkg::cell_ctrl_t               ctrl,
  input  logic                               valid_i,
  input  logic                               tail_i,
  input  logic [olle_pkg::DATA_W-1:0]        prev_data,
  input  logic [olle_pkg::DATA_W-1:0]        next_data,
  input  logic                               hit_in,
  output logic                               hit_out,
  output logic [olle_pkg::DATA_W-1:0]        data_o
);

  logic [olle_pkg::DATA_W-1:0] data_r;
  logic [olle_pkg::DATA_W-1:0] data_nxt;
  logic                        match;

  assign match   = ctrl.rem_val && valid_i && (data_r == ctrl.value);
  // The hit chain marks this cell and every cell behind the first match.
  assign hit_out = hit_in | match;
  assign data_o  = data_r;

  always_comb begin
    priority if (ctrl.shift_dn) begin
      data_nxt = prev_data;
    end else if (ctrl.load_tail && tail_i) begin
      data_nxt = ctrl.value;
    end else if (ctrl.shift_up || hit_out) begin
      data_nxt = next_data;
    end else begin
      data_nxt = data_r;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

endmodule

>>> hw/rtl/ordered_list_engine_core.sv
// ----------------------------------------------------------------------------
// ordered_list_engine_core: bounded ordered list of signed 32-bit values
// A row of list cells with a shared count register and a registered result.
// ----------------------------------------------------------------------------
// Each input beat carries one operation (insert front, insert back, remove
// back, remove front, remove first equal value) and produces exactly one
// output beat with a status and the entry count after the operation. The
// list lives in a row of olle_pkg::CAPACITY cells, front at cell 0; every
// cell compares its entry with the search value in the same cycle and a
// one-bit hit signal ripples down the row, so a removal by value, a shift
// toward the front or a shift toward the back all update the cells at once.
// The result is registered and valid in the cycle after the beat is accepted,
// and the block accepts one beat per cycle as long as the result register is
// empty or being drained in that same cycle. The ripple of the hit signal
// through all cells is the longest path of the design. Inserting into a full
// list returns status full, removing from an empty list returns status
// empty, and a value that is absent returns status not found; in all those
// cases the list is left unchanged. Unused action codes are ignored and
// return status ok. No clearing pass is needed after reset: only entries
// below the count are ever read.
// ----------------------------------------------------------------------------
module ordered_list_engine_core (
  input  logic                                 clk,
  input  logic                                 rst_n,
  // Input channel.
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  // Fields from bit 0: action[2:0], value[34:3], zero padding.
  input  logic [olle_pkg::IN_TDATA_W-1:0]      in_tdata,
  // Result channel.
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  // Fields from bit 0: status[1:0], entry_count[6:2], zero padding.
  output logic [olle_pkg::OUT_TDATA_W-1:0]     out_tdata
);

  localparam int N = olle_pkg::CAPACITY;

  logic [olle_pkg::ACT_W-1:0]   action;
  logic [olle_pkg::DATA_W-1:0]  value;
  logic                         fire;

  logic [olle_pkg::CNT_W-1:0]   count_r;
  logic [olle_pkg::CNT_W-1:0]   count_nxt;
  logic                         out_tvalid_r;
  logic                         out_tvalid_nxt;
  logic [olle_pkg::STAT_W-1:0]  status_r;
  logic [olle_pkg::STAT_W-1:0]  status_nxt;
  logic [olle_pkg::OCNT_W-1:0]  ocnt_r;

  logic                         full;
  logic                         empty;
  logic                         found;
  olle_pkg::cell_ctrl_t         ctrl;

  logic [N:0]                   hit;
  logic [olle_pkg::DATA_W-1:0]  cell_data [N];

  assign action = in_tdata[olle_pkg::ACT_W-1:0];
  assign value  = in_tdata[olle_pkg::ACT_W +: olle_pkg::DATA_W];

  // The result register is freed in the same cycle it is drained.
  assign in_tready = !out_tvalid_r || out_tready;
  assign fire      = in_tvalid && in_tready;

  assign full  = (count_r >= olle_pkg::CNT_W'(N));
  assign empty = (count_r == '0);
  assign found = hit[N];

  // Decode the operation into the cell control word. Cell moves are only
  // enabled for an accepted beat that succeeds. The compare runs on every
  // accepted removal by value so the status can be formed; on a stalled
  // beat the hit chain stays idle.
  always_comb begin
    ctrl       = '0;
    ctrl.value = value;
    unique case (action)
      olle_pkg::ACT_INS_FRONT: ctrl.shift_dn  = fire && !full;
      olle_pkg::ACT_INS_BACK:  ctrl.load_tail = fire && !full;
      olle_pkg::ACT_REM_FRONT: ctrl.shift_up  = fire && !empty;
      olle_pkg::ACT_REM_VALUE: ctrl.rem_val   = fire;
      default: ;
    endcase
  end

  // New count and status of the operation.
  always_comb begin
    count_nxt  = count_r;
    status_nxt = olle_pkg::ST_OK;
    unique case (action)
      olle_pkg::ACT_INS_FRONT,
      olle_pkg::ACT_INS_BACK: begin
        if (full) begin
          status_nxt = olle_pkg::ST_FULL;
        end else begin
          count_nxt = count_r + 1'b1;
        end
      end
      olle_pkg::ACT_REM_BACK,
      olle_pkg::ACT_REM_FRONT: begin
        if (empty) begin
          status_nxt = olle_pkg::ST_EMPTY;
        end else begin
          count_nxt = count_r - 1'b1;
        end
      end
      olle_pkg::ACT_REM_VALUE: begin
        if (empty) begin
          status_nxt = olle_pkg::ST_EMPTY;
        end else if (!found) begin
          status_nxt = olle_pkg::ST_NOT_FOUND;
        end else begin
          count_nxt = count_r - 1'b1;
        end
      end
      default: begin
        status_nxt = olle_pkg::ST_OK;
      end
    endcase
  end

  // Row of list cells. Cell 0 takes the new value on an insert at the front;
  // the last cell takes don't-care data when the row shifts toward the front,
  // which lands beyond the count.
  assign hit[0] = 1'b0;

  for (genvar i = 0; i < N; i++) begin : g_cell
    logic [olle_pkg::DATA_W-1:0] prev_d;
    logic [olle_pkg::DATA_W-1:0] next_d;

    if (i == 0) begin : g_first
      assign prev_d = value;
    end else begin : g_mid_prev
      assign prev_d = cell_data[i-1];
    end

    if (i == N - 1) begin : g_last
      assign next_d = '0;
    end else begin : g_mid_next
      assign next_d = cell_data[i+1];
    end

    olle_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .valid_i   (olle_pkg::CNT_W'(i) < count_r),
      .tail_i    (olle_pkg::CNT_W'(i) == count_r),
      .prev_data (prev_d),
      .next_data (next_d),
      .hit_in    (hit[i]),
      .hit_out   (hit[i+1]),
      .data_o    (cell_data[i])
    );
  end

  always_comb begin
    out_tvalid_nxt = out_tvalid_r;
    if (fire) begin
      out_tvalid_nxt = 1'b1;
    end else if (out_tready) begin
      out_tvalid_nxt = 1'b0;
    end
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r      <= '0;
      out_tvalid_r <= 1'b0;
    end else begin
      out_tvalid_r <= out_tvalid_nxt;
      if (fire) begin
        count_r <= count_nxt;
      end
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (fire) begin
      status_r <= status_nxt;
      ocnt_r   <= olle_pkg::OCNT_W'(count_nxt);
    end
  end

  assign out_tvalid = out_tvalid_r;
  assign out_tdata  = olle_pkg::OUT_TDATA_W'({ocnt_r, status_r});

endmodule

>>> sim/tb_ordered_list_engine_core.sv
// ----------------------------------------------------------------------------
// tb_ordered_list_engine_core: self-checking bench for the ordered list engine
// Drives list operations on the input stream, predicts every status and count
// in a queue-based model, and compares each result beat in order.
// ----------------------------------------------------------------------------
module tb_ordered_list_engine_core;
  import olle_pkg::*;

  // Action codes the block ignores.
  localparam logic [ACT_W-1:0] ACT_SPARE_LO = 3'd5;
  localparam logic [ACT_W-1:0] ACT_SPARE_HI = 3'd7;

  localparam int LONG_STALL_CYCLES = 200;
  localparam int DRAIN_LIMIT       = 2000;
  localparam int SWING_LEN         = 40;

  typedef struct packed {
    logic [STAT_W-1:0] status;
    logic [OCNT_W-1:0] entry_count;
  } list_result_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;

  logic [DATA_W-1:0] model_list[$];
  list_result_t      pending_results[$];
  list_result_t      head_result;
  int                mismatch_count = 0;
  int                tx_idle_pct = 0;
  int                rx_idle_pct = 0;
  bit                stall_request = 1'b0;

  ordered_list_engine_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Applies one operation to the model list and returns the status and count.
  function automatic list_result_t list_apply(input logic [ACT_W-1:0] act,
                                              input logic [DATA_W-1:0] operand);
    list_result_t r;
    int hit;
    hit = -1;
    r.status = ST_OK;
    case (act)
      ACT_INS_FRONT: begin
        if (model_list.size() >= CAPACITY) r.status = ST_FULL;
        else model_list.push_front(operand);
      end
      ACT_INS_BACK: begin
        if (model_list.size() >= CAPACITY) r.status = ST_FULL;
        else model_list.push_back(operand);
      end
      ACT_REM_BACK: begin
        if (model_list.size() == 0) r.status = ST_EMPTY;
        else void'(model_list.pop_back());
      end
      ACT_REM_FRONT: begin
        if (model_list.size() == 0) r.status = ST_EMPTY;
        else void'(model_list.pop_front());
      end
      ACT_REM_VALUE: begin
        if (model_list.size() == 0) begin
          r.status = ST_EMPTY;
        end else begin
          for (int i = 0; i < model_list.size() && hit < 0; i++)
            if (model_list[i] == operand) hit = i;
          if (hit < 0) r.status = ST_NOT_FOUND;
          else model_list.delete(hit);
        end
      end
      default: ;
    endcase
    r.entry_count = OCNT_W'(model_list.size());
    return r;
  endfunction

  // Offers one operation, waits for its beat to be taken, then records the
  // expected result. Random gaps come before the beat is raised.
  task automatic send_op(input logic [ACT_W-1:0] act, input logic [DATA_W-1:0] operand);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_TDATA_W - ACT_W - DATA_W){1'b0}}, operand, act};
    do @(posedge clk); while (!in_tready);
    pending_results.push_back(list_apply(act, operand));
  endtask

  // Mostly values that can collide or that sit in the list already, so that
  // removals by value find their target often.
  function automatic logic [DATA_W-1:0] pick_operand();
    case ($urandom_range(9))
      0, 1, 2: return $urandom;
      3, 4, 5: return DATA_W'($urandom_range(15)) - DATA_W'(8);
      6:       return $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
      default: return (model_list.size() > 0) ?
                      model_list[$urandom_range(model_list.size() - 1)] : $urandom;
    endcase
  endfunction

  // Insert-heavy and remove-heavy stretches alternate so the list swings
  // between empty and full again and again.
  task automatic random_op(input int insert_pct);
    int pick;
    logic [ACT_W-1:0] act;
    pick = $urandom_range(99);
    if (pick < 5)
      act = ACT_W'($urandom_range(ACT_SPARE_HI, ACT_SPARE_LO));
    else if (pick < 5 + insert_pct)
      act = $urandom_range(1) ? ACT_INS_BACK : ACT_INS_FRONT;
    else
      case ($urandom_range(2))
        0:       act = ACT_REM_BACK;
        1:       act = ACT_REM_FRONT;
        default: act = ACT_REM_VALUE;
      endcase
    send_op(act, pick_operand());
  endtask

  task automatic test_empty_and_single();
    send_op(ACT_REM_BACK, 32'h0);
    send_op(ACT_INS_FRONT, 32'h8000_0000);
    send_op(ACT_REM_BACK, 32'h0);          // only entry leaves from the back
    send_op(ACT_REM_FRONT, 32'hFFFF_FFFF);
    send_op(ACT_REM_VALUE, 32'h0);
    send_op(ACT_SPARE_HI, 32'hFFFF_FFFF);
  endtask

  task automatic test_fill_to_full();
    logic [DATA_W-1:0] fill_vals[16];
    fill_vals = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF,
                  32'h1, 32'h5555_5555, 32'hAAAA_AAAA, 32'h7,
                  32'h7, 32'hFFFF_FFFE, 32'h8000_0001, 32'h7FFF_FFFE,
                  32'h2, 32'h3, 32'hDEAD_BEEF, 32'h0F0F_0F0F};
    for (int i = 0; i < 16; i++)
      send_op(i[0] ? ACT_INS_FRONT : ACT_INS_BACK, fill_vals[i]);
    send_op(ACT_INS_FRONT, 32'h4);
    send_op(ACT_INS_BACK, 32'h5);
  endtask

  task automatic test_remove_by_value();
    send_op(ACT_REM_VALUE, 32'h7);          // duplicate: the front one goes
    send_op(ACT_REM_VALUE, 32'h1234_5678);  // absent
  endtask

  task automatic test_random_phase(input int tx_pct, input int rx_pct, input int n_ops);
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    for (int i = 0; i < n_ops; i++)
      random_op(((i / SWING_LEN) % 2) ? 20 : 75);
  endtask

  // The receiver holds off while the sender keeps offering beats, so the
  // result register stays full and the input must stall.
  task automatic test_backpressure();
    tx_idle_pct   = 0;
    rx_idle_pct   = 0;
    stall_request = 1'b1;
    for (int i = 0; i < 40; i++)
      random_op(50);
  endtask

  // Receiver: random ready, with one long hold-off counted here on request.
  initial begin
    bit stall_served;
    stall_served = 1'b0;
    forever begin
      @(posedge clk);
      if (stall_request && !stall_served) begin
        stall_served = 1'b1;
        out_tready <= 1'b0;
        repeat (LONG_STALL_CYCLES) @(posedge clk);
      end
      out_tready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result beat: status %0d count %0d", $time,
                 out_tdata[STAT_W-1:0], out_tdata[STAT_W +: OCNT_W]);
        mismatch_count++;
      end else begin
        head_result = pending_results.pop_front();
        if (out_tdata[STAT_W-1:0] !== head_result.status) begin
          $display("%0t: status mismatch: expected %0d, actual %0d", $time,
                   head_result.status, out_tdata[STAT_W-1:0]);
          mismatch_count++;
        end
        if (out_tdata[STAT_W +: OCNT_W] !== head_result.entry_count) begin
          $display("%0t: entry_count mismatch: expected %0d, actual %0d", $time,
                   head_result.entry_count, out_tdata[STAT_W +: OCNT_W]);
          mismatch_count++;
        end
      end
    end
  end

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    test_empty_and_single();
    test_fill_to_full();
    test_remove_by_value();
    test_random_phase(33, 70, 500);
    test_backpressure();
    test_random_phase(70, 33, 500);
    test_random_phase(0, 0, 500);
    in_tvalid <= 1'b0;
    for (int waited = 0; pending_results.size() > 0 && waited < DRAIN_LIMIT; waited++)
      @(posedge clk);
    repeat (4) @(posedge clk);
    if (pending_results.size() != 0) begin
      $display("%0t: %0d expected results never arrived", $time, pending_results.size());
      mismatch_count++;
    end
    if (mismatch_count == 0)
      $display("tb_ordered_list_engine_core: done, clean");
    else
      $display("tb_ordered_list_engine_core: done, errors");
    $finish;
  end

  initial begin
    #4000000;
    $display("%0t: timeout", $time);
    $display("tb_ordered_list_engine_core: done, errors");
    $finish;
  end

endmodule
